FILE: src/npps_pkg.sv
package npps_pkg;

  localparam int MAX_JOBS_DEF = 16;

  localparam int ARR_W      = 16;
  localparam int PRI_W      = 8;
  localparam int BURST_W    = 16;
  localparam int JOB_IDX_W  = 4;
  localparam int OUT_TIME_W = 21;

  // One stored job: {priority, arrival, burst}, the priority field on top so
  // that the whole word compares in serving order.
  localparam int JOB_W = PRI_W + ARR_W + BURST_W;

  typedef enum logic [2:0] {
    S_LOAD,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_FINISH,
    S_TURN,
    S_EMIT
  } sched_state_t;

  typedef struct packed {
    logic clear;     // start of a pass: forget the best candidate
    logic take;      // read data of one stored job is present
    logic min_mode;  // pass looks for the earliest unfinished arrival
  } scan_ctl_t;

endpackage

FILE: src/nonpreemptive_priority_scheduler.sv
// Channel  Transfer when        Payload
// in       in_valid & in_ready  arrival_time, job_priority, burst_time, last_job
// out      out_valid & out_ready job_index, completion_time, turnaround_time,
//                                waiting_time, overflow, last_result
//
// Loading accepts one job per cycle. A transfer with last_job set starts the
// schedule and in_ready stays low until the last result is in the output
// register. Each dispatch costs one to three passes over the n stored jobs
// through the single job RAM read port and one comparator, plus the shared
// adder in FINISH, TURN and EMIT. A stalled output holds the sequencer in
// EMIT. Reset (rst, synchronous) clears the sequencer, counts, done flags
// and the output valid; the job RAM is not cleared and is read only where
// written.
module nonpreemptive_priority_scheduler #(
  parameter int MAX_JOBS = npps_pkg::MAX_JOBS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [npps_pkg::ARR_W-1:0]      arrival_time,
  input  logic [npps_pkg::PRI_W-1:0]      job_priority,
  input  logic [npps_pkg::BURST_W-1:0]    burst_time,
  input  logic                            last_job,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [npps_pkg::JOB_IDX_W-1:0]  job_index,
  output logic [npps_pkg::OUT_TIME_W-1:0] completion_time,
  output logic [npps_pkg::OUT_TIME_W-1:0] turnaround_time,
  output logic [npps_pkg::OUT_TIME_W-1:0] waiting_time,
  output logic                            overflow,
  output logic                            last_result
);
  import npps_pkg::*;

  localparam int IDX_W  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W  = $clog2(MAX_JOBS + 1);
  // Latest arrival plus every burst still fits.
  localparam int TIME_W = (ARR_W + CNT_W > OUT_TIME_W) ? ARR_W + CNT_W : OUT_TIME_W;

  sched_state_t         state, state_next;
  logic                 mode_min;
  logic [IDX_W-1:0]     rd_idx;
  logic                 d_vld;
  logic [IDX_W-1:0]     d_idx;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     emitted;
  logic [TIME_W-1:0]    now;
  logic [TIME_W-1:0]    turn;
  logic                 ovf;
  logic [MAX_JOBS-1:0]  done;

  logic                 in_xfer;
  logic                 out_free;
  logic                 room;
  logic                 last_rd;
  logic                 final_res;
  logic                 start_pass;

  logic [JOB_W-1:0]     rd_job;
  scan_ctl_t            ctl;
  logic                 found;
  logic [IDX_W-1:0]     best_idx;
  logic [ARR_W-1:0]     best_arr;
  logic [BURST_W-1:0]   best_burst;

  logic [TIME_W-1:0]    alu_a, alu_b, alu_y;
  logic                 alu_sub;

  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign room      = count < CNT_W'(MAX_JOBS);
  assign last_rd   = CNT_W'(rd_idx) == count - 1'b1;
  assign final_res = emitted + 1'b1 == count;

  npps_ram #(
    .WIDTH (JOB_W),
    .DEPTH (MAX_JOBS)
  ) u_jobs (
    .clk   (clk),
    .we    (in_xfer && room),
    .waddr (count[IDX_W-1:0]),
    .wdata ({job_priority, arrival_time, burst_time}),
    .raddr (rd_idx),
    .rdata (rd_job)
  );

  assign ctl.clear    = start_pass;
  assign ctl.take     = d_vld;
  assign ctl.min_mode = mode_min;

  npps_scan #(
    .TIME_W (TIME_W),
    .IDX_W  (IDX_W)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .idx        (d_idx),
    .job        (rd_job),
    .done_bit   (done[d_idx]),
    .now        (now),
    .found      (found),
    .best_idx   (best_idx),
    .best_arr   (best_arr),
    .best_burst (best_burst)
  );

  // Shared adder: advance the clock, then turnaround, then waiting time.
  always_comb begin
    alu_a   = now;
    alu_b   = TIME_W'(best_burst);
    alu_sub = 1'b0;
    case (state)
      S_TURN: begin
        alu_b   = TIME_W'(best_arr);
        alu_sub = 1'b1;
      end
      S_EMIT: begin
        alu_a   = turn;
        alu_sub = 1'b1;
      end
      default: ;
    endcase
    alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + TIME_W'(alu_sub);
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    start_pass = 1'b0;
    case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_xfer && last_job) begin
          state_next = S_SCAN;
          start_pass = 1'b1;
        end
      end
      S_SCAN: begin
        if (last_rd) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_DECIDE;
      S_DECIDE: begin
        if (!mode_min && found) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_SCAN;
          start_pass = 1'b1;
        end
      end
      S_FINISH: state_next = S_TURN;
      S_TURN:   state_next = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          if (final_res) begin
            state_next = S_LOAD;
          end else begin
            state_next = S_SCAN;
            start_pass = 1'b1;
          end
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer counters and schedule state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_min <= 1'b0;
      rd_idx   <= '0;
      d_vld    <= 1'b0;
      count    <= '0;
      emitted  <= '0;
      now      <= '0;
      ovf      <= 1'b0;
      done     <= '0;
    end else begin
      d_vld <= state == S_SCAN;
      if (start_pass) begin
        rd_idx <= '0;
      end else if (state == S_SCAN && !last_rd) begin
        rd_idx <= rd_idx + 1'b1;
      end
      case (state)
        S_LOAD: begin
          if (in_xfer) begin
            if (room) begin
              count <= count + 1'b1;
            end else begin
              ovf <= 1'b1;
            end
          end
        end
        S_DECIDE: begin
          // No ready job: find the next arrival, jump there, pick again.
          if (mode_min) begin
            now      <= TIME_W'(best_arr);
            mode_min <= 1'b0;
          end else if (!found) begin
            mode_min <= 1'b1;
          end
        end
        S_FINISH: now <= alu_y;
        S_EMIT: begin
          if (out_free) begin
            if (final_res) begin
              count   <= '0;
              emitted <= '0;
              now     <= '0;
              ovf     <= 1'b0;
              done    <= '0;
            end else begin
              emitted        <= emitted + 1'b1;
              done[best_idx] <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    d_idx <= rd_idx;
    if (state == S_TURN) begin
      turn <= alu_y;
    end
  end

  // Output register: a result waits here while the sequencer scans on or loading resumes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      job_index       <= JOB_IDX_W'(best_idx);
      completion_time <= now[OUT_TIME_W-1:0];
      turnaround_time <= turn[OUT_TIME_W-1:0];
      waiting_time    <= alu_y[OUT_TIME_W-1:0];
      overflow        <= ovf;
      last_result     <= final_res;
    end
  end

endmodule

FILE: src/npps_ram.sv
module npps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/npps_scan.sv
module npps_scan #(
  parameter int TIME_W = 21,
  parameter int IDX_W  = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  npps_pkg::scan_ctl_t          ctl,
  input  logic [IDX_W-1:0]             idx,
  input  logic [npps_pkg::JOB_W-1:0]   job,
  input  logic                         done_bit,
  input  logic [TIME_W-1:0]            now,
  output logic                         found,
  output logic [IDX_W-1:0]             best_idx,
  output logic [npps_pkg::ARR_W-1:0]   best_arr,
  output logic [npps_pkg::BURST_W-1:0] best_burst
);
  import npps_pkg::*;

  logic [JOB_W-1:0]   best_job;
  logic [ARR_W-1:0]   cand_arr;
  logic [JOB_W-1:0]   cand_key;
  logic [JOB_W-1:0]   best_key;
  logic               elig;
  logic               better;

  assign cand_arr   = job[BURST_W +: ARR_W];
  assign best_arr   = best_job[BURST_W +: ARR_W];
  assign best_burst = best_job[BURST_W-1:0];

  // Earliest-arrival passes compare on arrival alone.
  assign cand_key = ctl.min_mode ? {{PRI_W{1'b0}}, cand_arr, {BURST_W{1'b0}}} : job;
  assign best_key = ctl.min_mode ? {{PRI_W{1'b0}}, best_arr, {BURST_W{1'b0}}} : best_job;

  assign elig   = !done_bit && (ctl.min_mode || TIME_W'(cand_arr) <= now);
  // Strict less: on a full tie the lower index, seen first, stays.
  assign better = !found || (cand_key < best_key);

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.clear) begin
      found <= 1'b0;
    end else if (ctl.take && elig) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take && elig && better) begin
      best_job <= job;
      best_idx <= idx;
    end
  end

endmodule

FILE: src/npps_check.sv
module npps_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [npps_pkg::ARR_W-1:0]      arrival_time,
  input logic [npps_pkg::PRI_W-1:0]      job_priority,
  input logic [npps_pkg::BURST_W-1:0]    burst_time,
  input logic                            last_job,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [npps_pkg::JOB_IDX_W-1:0]  job_index,
  input logic [npps_pkg::OUT_TIME_W-1:0] completion_time,
  input logic [npps_pkg::OUT_TIME_W-1:0] turnaround_time,
  input logic [npps_pkg::OUT_TIME_W-1:0] waiting_time,
  input logic                            overflow,
  input logic                            last_result
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(job_index)
      && $stable(completion_time) && $stable(last_result))
    else $error("stalled result changed");

  // Drop input ready once a job set starts scheduling.
  a_sched_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_job |=> !in_ready)
    else $error("input taken while scheduling");

  // A pending result that is not the last one means scheduling is under way.
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_result |-> !in_ready)
    else $error("input ready in the middle of a schedule");

  // Keep the overflow flag across all results of one schedule.
  a_ovf_steady: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_result |=> !out_valid || overflow == $past(overflow))
    else $error("overflow changed within a schedule");

  // Timing arithmetic is consistent on every result.
  a_times: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> turnaround_time <= completion_time && waiting_time <= turnaround_time)
    else $error("result times out of order");

endmodule

bind nonpreemptive_priority_scheduler npps_check u_check (.*);

FILE: sim/tb_nonpreemptive_priority_scheduler.sv
module tb_nonpreemptive_priority_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import npps_pkg::*;

  localparam int JOBS         = MAX_JOBS_DEF;
  localparam int ITEM_TARGET  = 320;   // input transfers before the stimulus stops
  localparam int STALL_LIMIT  = 5000;  // cycles without any transfer before giving up
  localparam int HOLD_AFTER   = 60;    // results seen before the long output hold-off
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 200;   // settle time after the last expected result
  localparam int SHOW_LIMIT   = 10;

  // Content styles for one randomized job set.
  typedef enum int {
    SHAPE_TIGHT,  // close arrivals, few priority levels, short bursts: many ties
    SHAPE_MIXED,  // moderate spread, occasional long burst
    SHAPE_WIDE    // full field ranges: idle jumps and large times
  } set_shape_t;

  // One finished job as the block reports it.
  typedef struct packed {
    logic [JOB_IDX_W-1:0]  idx;
    logic [OUT_TIME_W-1:0] done_at;
    logic [OUT_TIME_W-1:0] turnaround;
    logic [OUT_TIME_W-1:0] waited;
    logic                  ovf;
    logic                  last;
  } job_report_t;

  // Scoreboard: keeps its own copy of the job store, runs the schedule when the
  // last job of a set is accepted, and matches results in completion order.
  class schedule_scoreboard;
    logic [ARR_W-1:0]   arrival [JOBS];
    logic [PRI_W-1:0]   prio    [JOBS];
    logic [BURST_W-1:0] burst   [JOBS];
    bit                 done    [JOBS];
    int                 loaded;
    bit                 dropped;
    job_report_t        finish_order_q[$];
    int                 mismatches;

    function new();
      loaded     = 0;
      dropped    = 1'b0;
      mismatches = 0;
      done       = '{default: 1'b0};
    endfunction

    // Serving order: priority number, then arrival, then burst, then load index.
    function bit goes_ahead(int a, int b);
      if (prio[a] != prio[b])
        return prio[a] < prio[b];
      if (arrival[a] != arrival[b])
        return arrival[a] < arrival[b];
      if (burst[a] != burst[b])
        return burst[a] < burst[b];
      return a < b;
    endfunction

    function int best_ready(int unsigned now);
      int pick;
      pick = -1;
      for (int j = 0; j < loaded; j++)
        if (!done[j] && arrival[j] <= now && (pick < 0 || goes_ahead(j, pick)))
          pick = j;
      return pick;
    endfunction

    function void run_schedule();
      int unsigned now;
      int unsigned turn;
      int unsigned waited_full;
      int          pick;
      job_report_t rep;
      now = 32'(arrival[0]);
      for (int j = 1; j < loaded; j++)
        if (arrival[j] < now)
          now = 32'(arrival[j]);
      for (int k = 0; k < loaded; k++) begin
        pick = best_ready(now);
        if (pick < 0) begin
          // nothing ready: jump to the next unfinished arrival
          now = '1;
          for (int j = 0; j < loaded; j++)
            if (!done[j] && arrival[j] < now)
              now = 32'(arrival[j]);
          pick = best_ready(now);
        end
        done[pick]  = 1'b1;
        now         = now + 32'(burst[pick]);
        turn        = now - 32'(arrival[pick]);
        waited_full = turn - 32'(burst[pick]);
        rep.idx        = pick[JOB_IDX_W-1:0];
        rep.done_at    = now[OUT_TIME_W-1:0];
        rep.turnaround = turn[OUT_TIME_W-1:0];
        rep.waited     = waited_full[OUT_TIME_W-1:0];
        rep.ovf        = dropped;
        rep.last       = (k == loaded - 1);
        finish_order_q = {finish_order_q, rep};
      end
      done    = '{default: 1'b0};
      loaded  = 0;
      dropped = 1'b0;
    endfunction

    function void note_job(logic [ARR_W-1:0] arr, logic [PRI_W-1:0] pri,
                           logic [BURST_W-1:0] bur, logic lst);
      if (loaded < JOBS) begin
        arrival[loaded] = arr;
        prio[loaded]    = pri;
        burst[loaded]   = bur;
        done[loaded]    = 1'b0;
        loaded++;
      end else begin
        dropped = 1'b1;
      end
      if (lst)
        run_schedule();
    endfunction

    function void check_result(job_report_t got);
      job_report_t want;
      if (finish_order_q.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("unexpected result: idx %0d done %0d turn %0d wait %0d ovf %0b last %0b",
                   got.idx, got.done_at, got.turnaround, got.waited, got.ovf, got.last);
        return;
      end
      want = finish_order_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT) begin
          $display("result mismatch: expected idx %0d done %0d turn %0d wait %0d ovf %0b last %0b",
                   want.idx, want.done_at, want.turnaround, want.waited, want.ovf, want.last);
          $display("                      got idx %0d done %0d turn %0d wait %0d ovf %0b last %0b",
                   got.idx, got.done_at, got.turnaround, got.waited, got.ovf, got.last);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [ARR_W-1:0]      arrival_time;
  logic [PRI_W-1:0]      job_priority;
  logic [BURST_W-1:0]    burst_time;
  logic                  last_job;
  logic                  out_valid;
  logic                  out_ready;
  logic [JOB_IDX_W-1:0]  job_index;
  logic [OUT_TIME_W-1:0] completion_time;
  logic [OUT_TIME_W-1:0] turnaround_time;
  logic [OUT_TIME_W-1:0] waiting_time;
  logic                  overflow;
  logic                  last_result;

  schedule_scoreboard sb = new();

  int items_sent   = 0;
  int results_seen = 0;
  bit steady       = 1'b0;  // when set, neither side idles randomly between transfers

  nonpreemptive_priority_scheduler dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .arrival_time    (arrival_time),
    .job_priority    (job_priority),
    .burst_time      (burst_time),
    .last_job        (last_job),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .job_index       (job_index),
    .completion_time (completion_time),
    .turnaround_time (turnaround_time),
    .waiting_time    (waiting_time),
    .overflow        (overflow),
    .last_result     (last_result)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Offer one job: optionally idle first, then hold valid and payload until the
  // transfer, and hand the accepted job to the scoreboard.
  task automatic send_job(input logic [ARR_W-1:0] arr, input logic [PRI_W-1:0] pri,
                          input logic [BURST_W-1:0] bur, input logic lst);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    arrival_time <= arr;
    job_priority <= pri;
    burst_time   <= bur;
    last_job     <= lst;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_job(arr, pri, bur, lst);
    items_sent++;
  endtask

  // Send a set of n jobs, the last one flagged; n above capacity drops the tail.
  task automatic send_set(input int n, input set_shape_t shape);
    logic [ARR_W-1:0]   arr;
    logic [PRI_W-1:0]   pri;
    logic [BURST_W-1:0] bur;
    for (int i = 0; i < n; i++) begin
      case (shape)
        SHAPE_TIGHT: begin
          arr = ARR_W'($urandom_range(0, 40));
          pri = PRI_W'($urandom_range(0, 3));
          bur = BURST_W'($urandom_range(0, 20));
        end
        SHAPE_MIXED: begin
          arr = ARR_W'($urandom_range(0, 2000));
          pri = PRI_W'($urandom_range(0, 255));
          bur = BURST_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                      : $urandom_range(0, 300));
        end
        default: begin
          arr = ARR_W'($urandom_range(0, 65535));
          pri = PRI_W'($urandom_range(0, 255));
          bur = BURST_W'($urandom_range(0, 65535));
        end
      endcase
      send_job(arr, pri, bur, i == n - 1);
    end
  endtask

  // Receiver: idle a random count before each transfer, hold off once for a
  // long stretch so the block backs up into its input, check every result.
  initial begin : receiver
    int          gap;
    bit          held;
    job_report_t got;
    held = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 3);
      if (!held && results_seen >= HOLD_AFTER) begin
        gap  = HOLD_CYCLES;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      got = '{job_index, completion_time, turnaround_time, waiting_time, overflow, last_result};
      sb.check_result(got);
      results_seen++;
    end
  end

  // Watchdog: end the run when no transfer happens on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int n;
    int roll;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    arrival_time <= '0;
    job_priority <= '0;
    burst_time   <= '0;
    last_job     <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single job at the top of every field.
    send_job(16'hFFFF, 8'hFF, 16'hFFFF, 1'b1);

    // Tie breaks: a zero-burst job first, an idle jump, then equal priorities
    // sorted by arrival, then burst, then load index.
    send_job(16'd5, 8'd2, 16'd10, 1'b0);
    send_job(16'd5, 8'd2, 16'd3,  1'b0);
    send_job(16'd2, 8'd2, 16'd3,  1'b0);
    send_job(16'd5, 8'd2, 16'd3,  1'b0);
    send_job(16'd0, 8'd7, 16'd0,  1'b0);
    send_job(16'd4, 8'd2, 16'd20, 1'b1);

    // A running job is never preempted by a better one arriving meanwhile.
    send_job(16'd300, 8'd1, 16'd40,  1'b0);
    send_job(16'd310, 8'd0, 16'd5,   1'b0);
    send_job(16'd100, 8'd9, 16'd250, 1'b1);

    // Full store, then a flagged job that finds no room and is dropped.
    send_set(JOBS + 1, SHAPE_TIGHT);

    // Random sets: mostly small, some large up to full size, a few over capacity.
    while (items_sent < ITEM_TARGET) begin
      roll = $urandom_range(0, 15);
      if (roll == 0)
        n = $urandom_range(JOBS + 1, JOBS + 4);
      else if (roll < 4)
        n = $urandom_range(9, JOBS);
      else
        n = $urandom_range(1, 8);
      steady = ($urandom_range(0, 3) == 0);
      send_set(n, set_shape_t'($urandom_range(0, 2)));
    end

    // Drop valid, wait out the remaining results, then let the block settle.
    in_valid <= 1'b0;
    while (sb.finish_order_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.finish_order_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
